// ===== rtl/source_text_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== rtl/stt_pkg.sv =====
// Shared types, token kind codes, character codes and byte classifiers
// for the source text tokenizer. No dependencies.
package stt_pkg;

    // Default field widths and fixed sizes.
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;
    localparam int KIND_BITS       = 5;
    localparam int MAX_TOKENS      = 4;
    localparam int CNT_BITS        = 3;
    localparam int SLOT_BITS       = 2;
    localparam int CAND_COUNT      = 6;

    typedef logic [KIND_BITS-1:0] kind_t;

    // Token kinds.
    localparam kind_t K_LPAREN    = kind_t'(0);
    localparam kind_t K_RPAREN    = kind_t'(1);
    localparam kind_t K_LBRACE    = kind_t'(2);
    localparam kind_t K_RBRACE    = kind_t'(3);
    localparam kind_t K_LBRACKET  = kind_t'(4);
    localparam kind_t K_RBRACKET  = kind_t'(5);
    localparam kind_t K_COMMA     = kind_t'(6);
    localparam kind_t K_DOT       = kind_t'(7);
    localparam kind_t K_MINUS     = kind_t'(8);
    localparam kind_t K_PLUS      = kind_t'(9);
    localparam kind_t K_SEMI      = kind_t'(10);
    localparam kind_t K_STAR      = kind_t'(11);
    localparam kind_t K_QUESTION  = kind_t'(12);
    localparam kind_t K_COLON     = kind_t'(13);
    localparam kind_t K_BANG      = kind_t'(14);
    localparam kind_t K_GREATER   = kind_t'(16);
    localparam kind_t K_LESS      = kind_t'(18);
    localparam kind_t K_EQUAL     = kind_t'(20);
    localparam kind_t K_SLASH     = kind_t'(22);
    localparam kind_t K_BACKSLASH = kind_t'(23);
    localparam kind_t K_STRING    = kind_t'(24);
    localparam kind_t K_NUMBER    = kind_t'(25);
    localparam kind_t K_IDENT     = kind_t'(26);
    localparam kind_t K_END       = kind_t'(27);
    localparam kind_t K_ERROR     = kind_t'(28);

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Scanner modes: which token, if any, is still open.
    typedef enum logic [3:0] {
        M_IDLE,
        M_OP,
        M_SLASH,
        M_COMMENT,
        M_STRING,
        M_INT,
        M_DOT,
        M_FRAC,
        M_IDENT
    } mode_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_NL, CH_SPACE, CH_TAB, CH_CR};
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return c inside {CH_BANG, CH_GREAT, CH_LESS, CH_EQUAL};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                         CH_COMMA, CH_DOT, CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR,
                         CH_QUEST, CH_COLON, CH_BSLASH};
    endfunction

    // Kind of a single-character punctuation byte.
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_LBRACK: k = K_LBRACKET;
            CH_RBRACK: k = K_RBRACKET;
            CH_COMMA:  k = K_COMMA;
            CH_DOT:    k = K_DOT;
            CH_MINUS:  k = K_MINUS;
            CH_PLUS:   k = K_PLUS;
            CH_SEMI:   k = K_SEMI;
            CH_STAR:   k = K_STAR;
            CH_QUEST:  k = K_QUESTION;
            CH_COLON:  k = K_COLON;
            default:   k = K_BACKSLASH;
        endcase
        return k;
    endfunction

    // Single-character kind of a comparison operator byte; the two-character
    // form with a trailing equals sign is the next code up.
    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_BANG:  k = K_BANG;
            CH_GREAT: k = K_GREATER;
            CH_LESS:  k = K_LESS;
            default:  k = K_EQUAL;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer: one ASCII byte per input beat in, one token per
// output beat. A byte is scanned in the cycle it is accepted and its tokens
// (up to four) land in a result buffer that drains one token a beat. A byte
// that closes no token and opens none shows nothing and holds nothing up; a
// byte that yields tokens holds the input until its last token leaves, since
// the result buffer has a single output port. Tokens appear the cycle after
// their byte. Offsets, lengths, lines and columns saturate at their field
// maximum. The byte flagged by s_tlast ends the text: open tokens are flushed,
// an end token follows, and all counters return to zero. Uses stt_pkg and stt_scan.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    localparam int DATA_BITS  = 2 * OFFSET_BITS + 2 * LINE_BITS,
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Byte input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // source_byte
    input  logic                  s_tlast,   // final_byte
    // Token output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: start_offset, token_length, line_number, column_number, zero fill.
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic [KIND_BITS-1:0]  m_tuser,   // token_kind
    output logic                  m_tlast    // last_of_run
);

    logic                                   accept;
    logic                                   pop;
    logic                                   drain_done;
    logic [CNT_BITS-1:0]                    scan_cnt;
    logic [MAX_TOKENS-1:0][KIND_BITS-1:0]   scan_kind;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] scan_start;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] scan_len;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   scan_line;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   scan_col;

    // Result buffer: the tokens of one byte and the slot being shown.
    logic [CNT_BITS-1:0]                    cnt_reg, cnt_next;
    logic [SLOT_BITS-1:0]                   idx_reg, idx_next;
    logic [MAX_TOKENS-1:0][KIND_BITS-1:0]   kind_reg;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] start_reg;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] len_reg;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   line_reg;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   col_reg;

    stt_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .byte_in   (s_tdata),
        .fin_in    (s_tlast),
        .tok_cnt   (scan_cnt),
        .tok_kind  (scan_kind),
        .tok_start (scan_start),
        .tok_len   (scan_len),
        .tok_line  (scan_line),
        .tok_col   (scan_col)
    );

    // Handshakes: a new byte is taken when the buffer is empty or its last
    // token leaves in this cycle.
    assign m_tvalid   = (cnt_reg != '0);
    assign m_tlast    = ({1'b0, idx_reg} == (cnt_reg - CNT_BITS'(1)));
    assign pop        = m_tvalid && m_tready;
    assign drain_done = pop && m_tlast;
    assign s_tready   = (cnt_reg == '0) || drain_done;
    assign accept     = s_tvalid && s_tready;

    // Output beat from the current slot.
    assign m_tuser = kind_reg[idx_reg];
    assign m_tdata = TDATA_BITS'({col_reg[idx_reg], line_reg[idx_reg],
                                  len_reg[idx_reg], start_reg[idx_reg]});

    // Buffer fill level and read slot.
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (accept) begin
            cnt_next = scan_cnt;
            idx_next = '0;
        end else if (drain_done) begin
            cnt_next = '0;
            idx_next = '0;
        end else if (pop) begin
            idx_next = idx_reg + SLOT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Token payload is loaded with each accepted byte.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= scan_kind;
            start_reg <= scan_start;
            len_reg   <= scan_len;
            line_reg  <= scan_line;
            col_reg   <= scan_col;
        end
    end

    // The buffer never claims more tokens than it has slots.
    `STT_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_BITS'(MAX_TOKENS))
    // A byte is taken over a non-empty buffer only as its last token leaves.
    `STT_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, accept && (cnt_reg != '0), drain_done)
    // A token that is not the last of its byte is followed by the next slot.
    `STT_ASSERT_NEXT(a_slot_step, aclk, aresetn, pop && !m_tlast,
                     (idx_reg == $past(idx_reg) + SLOT_BITS'(1)) && $stable(cnt_reg))
    // The final byte of a text always yields at least the end token.
    `STT_ASSERT_NEXT(a_end_token, aclk, aresetn, accept && s_tlast, m_tvalid)

endmodule

// ===== rtl/stt_scan.sv =====
// Scanner core of the tokenizer: holds the lexer state and position
// counters and turns one byte into up to four tokens. Uses stt_pkg.
module stt_scan
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    step,
    input  logic [7:0]                              byte_in,
    input  logic                                    fin_in,
    output logic [CNT_BITS-1:0]                     tok_cnt,
    output logic [MAX_TOKENS-1:0][KIND_BITS-1:0]    tok_kind,
    output logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0]  tok_start,
    output logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0]  tok_len,
    output logic [MAX_TOKENS-1:0][LINE_BITS-1:0]    tok_line,
    output logic [MAX_TOKENS-1:0][LINE_BITS-1:0]    tok_col
);

    localparam int SUM_BITS = ((OFFSET_BITS > LINE_BITS) ? OFFSET_BITS : LINE_BITS) + 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

    // Saturating arithmetic on offsets, lines and columns.
    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] a);
        return (a == OFF_MAX) ? a : a + OFFSET_BITS'(1);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] off_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [OFFSET_BITS-1:0] b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] lin_inc(input logic [LINE_BITS-1:0] a);
        return (a == LIN_MAX) ? a : a + LINE_BITS'(1);
    endfunction

    function automatic logic [LINE_BITS-1:0] col_add(input logic [LINE_BITS-1:0] a,
                                                     input logic [OFFSET_BITS-1:0] b);
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(a) + SUM_BITS'(b);
        return (s > SUM_BITS'(LIN_MAX)) ? LIN_MAX : s[LINE_BITS-1:0];
    endfunction

    // Lexer state.
    mode_t                  mode_reg, mode_next;
    kind_t                  opk_reg, opk_next;
    logic [OFFSET_BITS-1:0] ps_reg, ps_next;
    logic [OFFSET_BITS-1:0] pl_reg, pl_next;
    logic [LINE_BITS-1:0]   pln_reg, pln_next;
    logic [LINE_BITS-1:0]   pc_reg, pc_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   col_reg, col_next;

    // Candidate tokens in emission order: closed pending token, held dot,
    // token of the byte scanned afresh, flushed pending token, flushed dot, end.
    logic [CAND_COUNT-1:0]  c_vld;
    kind_t                  c_kind  [CAND_COUNT];
    logic [OFFSET_BITS-1:0] c_start [CAND_COUNT];
    logic [OFFSET_BITS-1:0] c_len   [CAND_COUNT];
    logic [LINE_BITS-1:0]   c_line  [CAND_COUNT];
    logic [LINE_BITS-1:0]   c_col   [CAND_COUNT];

    logic                   used;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [LINE_BITS-1:0]   col_inc;
    logic [CNT_BITS-1:0]    n;

    // Next state and candidate tokens for the byte on the input.
    always_comb begin
        mode_next = mode_reg;
        opk_next  = opk_reg;
        ps_next   = ps_reg;
        pl_next   = pl_reg;
        pln_next  = pln_reg;
        pc_next   = pc_reg;
        used      = 1'b1;
        c_vld     = '0;

        c_kind[0]  = K_NUMBER;
        c_start[0] = ps_reg;
        c_len[0]   = pl_reg;
        c_line[0]  = pln_reg;
        c_col[0]   = pc_reg;

        c_kind[1]  = K_DOT;
        c_start[1] = off_add(ps_reg, pl_reg);
        c_len[1]   = OFFSET_BITS'(1);
        c_line[1]  = pln_reg;
        c_col[1]   = col_add(pc_reg, pl_reg);

        c_kind[2]  = K_ERROR;
        c_start[2] = pos_reg;
        c_len[2]   = OFFSET_BITS'(1);
        c_line[2]  = line_reg;
        c_col[2]   = col_reg;

        // Continue or close the open token.
        case (mode_reg)
            M_OP: begin
                mode_next = M_IDLE;
                c_vld[0]  = 1'b1;
                if (byte_in == CH_EQUAL) begin
                    pl_next   = OFFSET_BITS'(2);
                    c_kind[0] = opk_reg + KIND_BITS'(1);
                    c_len[0]  = OFFSET_BITS'(2);
                end else begin
                    c_kind[0] = opk_reg;
                    used      = 1'b0;
                end
            end
            M_SLASH: begin
                if (byte_in == CH_SLASH) begin
                    mode_next = M_COMMENT;
                end else begin
                    mode_next = M_IDLE;
                    c_vld[0]  = 1'b1;
                    c_kind[0] = K_SLASH;
                    used      = 1'b0;
                end
            end
            M_COMMENT: begin
                if (byte_in == CH_NL) begin
                    mode_next = M_IDLE;
                    used      = 1'b0;
                end
            end
            M_STRING: begin
                if (byte_in == CH_QUOTE) begin
                    mode_next = M_IDLE;
                    c_vld[0]  = 1'b1;
                    c_kind[0] = K_STRING;
                end else begin
                    pl_next = off_inc(pl_reg);
                end
            end
            M_INT, M_FRAC: begin
                if (is_digit(byte_in)) begin
                    pl_next = off_inc(pl_reg);
                end else if (byte_in == CH_DOT && mode_reg == M_INT) begin
                    mode_next = M_DOT;
                end else begin
                    mode_next = M_IDLE;
                    c_vld[0]  = 1'b1;
                    used      = 1'b0;
                end
            end
            M_DOT: begin
                if (is_digit(byte_in)) begin
                    pl_next   = off_add(pl_reg, OFFSET_BITS'(2));
                    mode_next = M_FRAC;
                end else begin
                    mode_next = M_IDLE;
                    c_vld[1:0] = 2'b11;
                    used      = 1'b0;
                end
            end
            M_IDENT: begin
                if (is_word(byte_in)) begin
                    pl_next = off_inc(pl_reg);
                end else begin
                    mode_next = M_IDLE;
                    c_vld[0]  = 1'b1;
                    c_kind[0] = K_IDENT;
                    used      = 1'b0;
                end
            end
            default: begin
                mode_next = M_IDLE;
                used      = 1'b0;
            end
        endcase

        // Scan the byte afresh when the open token did not take it.
        if (!used) begin
            if (is_punct(byte_in)) begin
                c_vld[2]  = 1'b1;
                c_kind[2] = punct_kind(byte_in);
            end else if (is_op_char(byte_in)) begin
                mode_next = M_OP;
                opk_next  = op_kind(byte_in);
                ps_next   = pos_reg;
                pl_next   = OFFSET_BITS'(1);
                pln_next  = line_reg;
                pc_next   = col_reg;
            end else if (byte_in == CH_SLASH) begin
                mode_next = M_SLASH;
                ps_next   = pos_reg;
                pl_next   = OFFSET_BITS'(1);
                pln_next  = line_reg;
                pc_next   = col_reg;
            end else if (byte_in == CH_QUOTE) begin
                mode_next = M_STRING;
                ps_next   = off_inc(pos_reg);
                pl_next   = '0;
                pln_next  = line_reg;
                pc_next   = col_reg;
            end else if (is_space(byte_in)) begin
                mode_next = M_IDLE;
            end else if (is_word(byte_in)) begin
                mode_next = is_digit(byte_in) ? M_INT : M_IDENT;
                ps_next   = pos_reg;
                pl_next   = OFFSET_BITS'(1);
                pln_next  = line_reg;
                pc_next   = col_reg;
            end else begin
                c_vld[2] = 1'b1;
            end
        end

        // Position counters move for every byte.
        pos_inc  = off_inc(pos_reg);
        line_inc = (byte_in == CH_NL) ? lin_inc(line_reg) : line_reg;
        col_inc  = (byte_in == CH_NL) ? '0 : lin_inc(col_reg);
        pos_next  = pos_inc;
        line_next = line_inc;
        col_next  = col_inc;

        // Flush at the end of the text.
        c_kind[3]  = K_NUMBER;
        c_start[3] = ps_next;
        c_len[3]   = pl_next;
        c_line[3]  = pln_next;
        c_col[3]   = pc_next;

        c_kind[4]  = K_DOT;
        c_start[4] = off_add(ps_next, pl_next);
        c_len[4]   = OFFSET_BITS'(1);
        c_line[4]  = pln_next;
        c_col[4]   = col_add(pc_next, pl_next);

        c_kind[5]  = K_END;
        c_start[5] = pos_inc;
        c_len[5]   = '0;
        c_line[5]  = line_inc;
        c_col[5]   = col_inc;

        if (fin_in) begin
            c_vld[5] = 1'b1;
            case (mode_next)
                M_OP: begin
                    c_vld[3]  = 1'b1;
                    c_kind[3] = opk_next;
                end
                M_SLASH: begin
                    c_vld[3]  = 1'b1;
                    c_kind[3] = K_SLASH;
                end
                M_STRING: begin
                    c_vld[3]  = 1'b1;
                    c_kind[3] = K_STRING;
                end
                M_INT, M_FRAC: begin
                    c_vld[3] = 1'b1;
                end
                M_DOT: begin
                    c_vld[4:3] = 2'b11;
                end
                M_IDENT: begin
                    c_vld[3]  = 1'b1;
                    c_kind[3] = K_IDENT;
                end
                default: begin
                end
            endcase
            // The next byte starts a new text.
            mode_next = M_IDLE;
            opk_next  = K_LPAREN;
            ps_next   = '0;
            pl_next   = '0;
            pln_next  = '0;
            pc_next   = '0;
            pos_next  = '0;
            line_next = '0;
            col_next  = '0;
        end
    end

    // Pack the valid candidates into consecutive token slots.
    always_comb begin
        n         = '0;
        tok_kind  = '0;
        tok_start = '0;
        tok_len   = '0;
        tok_line  = '0;
        tok_col   = '0;
        for (int i = 0; i < CAND_COUNT; i++) begin
            if (c_vld[i] && n < CNT_BITS'(MAX_TOKENS)) begin
                tok_kind[n[SLOT_BITS-1:0]]  = c_kind[i];
                tok_start[n[SLOT_BITS-1:0]] = c_start[i];
                tok_len[n[SLOT_BITS-1:0]]   = c_len[i];
                tok_line[n[SLOT_BITS-1:0]]  = c_line[i];
                tok_col[n[SLOT_BITS-1:0]]   = c_col[i];
                n = n + CNT_BITS'(1);
            end
        end
        tok_cnt = n;
    end

    // State advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            opk_reg  <= K_LPAREN;
            ps_reg   <= '0;
            pl_reg   <= '0;
            pln_reg  <= '0;
            pc_reg   <= '0;
            pos_reg  <= '0;
            line_reg <= '0;
            col_reg  <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            opk_reg  <= opk_next;
            ps_reg   <= ps_next;
            pl_reg   <= pl_next;
            pln_reg  <= pln_next;
            pc_reg   <= pc_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for source_text_tokenizer: byte stream in, token beats out.
// Predicts every token from its own scanner model and compares each output beat.
// Depends on stt_pkg and the tokenizer RTL only.
`timescale 1ns / 100ps

module testbench;
    import stt_pkg::*;

    localparam int OFFSET_W = 24;
    localparam int LINE_W   = 16;
    localparam int TDATA_W  = ((2 * OFFSET_W + 2 * LINE_W + 7) / 8) * 8;
    localparam longint OFF_MAX = (longint'(1) << OFFSET_W) - 1;
    localparam longint LIN_MAX = (longint'(1) << LINE_W) - 1;
    localparam int RANDOM_BYTES = 390;
    localparam int HOLD_AFTER   = 100;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [7:0] data;
        logic       final_flag;
        logic       drain_first;
    } src_byte_t;

    typedef struct {
        kind_t               kind;
        logic [OFFSET_W-1:0] start;
        logic [OFFSET_W-1:0] length;
        logic [LINE_W-1:0]   line;
        logic [LINE_W-1:0]   column;
        logic                last_flag;
    } token_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;  // source_byte
    logic               s_tlast  = 1'b0;   // final_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // From bit 0: start_offset, token_length, line_number, column_number.
    logic [TDATA_W-1:0] m_tdata;
    logic [4:0]         m_tuser;           // token_kind
    logic               m_tlast;           // last_of_run

    source_text_tokenizer #(
        .OFFSET_BITS(OFFSET_W),
        .LINE_BITS  (LINE_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    src_byte_t  byte_queue[$];
    token_t     token_queue[$];
    token_t     run_tokens[$];
    logic [7:0] text_bytes[$];
    int         fail_count     = 0;
    int         bytes_total    = 0;
    int         bytes_accepted = 0;
    int         tokens_seen    = 0;

    // Scanner state of the predictor.
    mode_t               scan_state = M_IDLE;
    kind_t               held_op    = K_BANG;
    logic [OFFSET_W-1:0] pend_start = '0;
    logic [OFFSET_W-1:0] pend_len   = '0;
    logic [LINE_W-1:0]   pend_line  = '0;
    logic [LINE_W-1:0]   pend_col   = '0;
    logic [OFFSET_W-1:0] byte_pos   = '0;
    logic [LINE_W-1:0]   cur_line   = '0;
    logic [LINE_W-1:0]   cur_col    = '0;

    function automatic logic [OFFSET_W-1:0] off_add(input longint a, input longint n);
        longint s;
        s = a + n;
        return OFFSET_W'((s > OFF_MAX) ? OFF_MAX : s);
    endfunction

    function automatic logic [LINE_W-1:0] line_add(input longint a, input longint n);
        longint s;
        s = a + n;
        return LINE_W'((s > LIN_MAX) ? LIN_MAX : s);
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return digit_byte(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == CH_UNDER;
    endfunction

    // Kind of a one-byte punctuation token, or -1 when the byte is not one.
    function automatic int punct_code(input logic [7:0] c);
        case (c)
            CH_LPAREN: return K_LPAREN;
            CH_RPAREN: return K_RPAREN;
            CH_LBRACE: return K_LBRACE;
            CH_RBRACE: return K_RBRACE;
            CH_LBRACK: return K_LBRACKET;
            CH_RBRACK: return K_RBRACKET;
            CH_COMMA:  return K_COMMA;
            CH_DOT:    return K_DOT;
            CH_MINUS:  return K_MINUS;
            CH_PLUS:   return K_PLUS;
            CH_SEMI:   return K_SEMI;
            CH_STAR:   return K_STAR;
            CH_QUEST:  return K_QUESTION;
            CH_COLON:  return K_COLON;
            CH_BSLASH: return K_BACKSLASH;
            default:   return -1;
        endcase
    endfunction

    task automatic add_token(input kind_t k, input logic [OFFSET_W-1:0] st,
                             input logic [OFFSET_W-1:0] len, input logic [LINE_W-1:0] ln,
                             input logic [LINE_W-1:0] col);
        token_t t;
        t.kind      = k;
        t.start     = st;
        t.length    = len;
        t.line      = ln;
        t.column    = col;
        t.last_flag = 1'b0;
        run_tokens.push_back(t);
    endtask

    // A number followed by a dot that no digit joined: both tokens come out.
    task automatic add_number_and_dot();
        add_token(K_NUMBER, pend_start, pend_len, pend_line, pend_col);
        add_token(K_DOT, off_add(pend_start, pend_len), OFFSET_W'(1), pend_line,
                  line_add(pend_col, pend_len));
    endtask

    task automatic open_pending(input mode_t m, input logic [OFFSET_W-1:0] st,
                                input logic [OFFSET_W-1:0] len);
        scan_state = m;
        pend_start = st;
        pend_len   = len;
        pend_line  = cur_line;
        pend_col   = cur_col;
    endtask

    // Predicts the tokens caused by one source byte and queues them.
    task automatic scan_byte(input logic [7:0] b, input logic fin);
        logic rescan;
        int   pk;
        rescan = 1'b0;
        run_tokens.delete();

        // Close or extend whatever token is open.
        case (scan_state)
            M_OP: begin
                if (b == CH_EQUAL) begin
                    pend_len = OFFSET_W'(2);
                    add_token(kind_t'(held_op + 1), pend_start, pend_len, pend_line, pend_col);
                end else begin
                    add_token(held_op, pend_start, pend_len, pend_line, pend_col);
                    rescan = 1'b1;
                end
                scan_state = M_IDLE;
            end
            M_SLASH: begin
                if (b == CH_SLASH) begin
                    scan_state = M_COMMENT;
                end else begin
                    add_token(K_SLASH, pend_start, pend_len, pend_line, pend_col);
                    scan_state = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_COMMENT: begin
                if (b == CH_NL) begin
                    scan_state = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_STRING: begin
                if (b == CH_QUOTE) begin
                    add_token(K_STRING, pend_start, pend_len, pend_line, pend_col);
                    scan_state = M_IDLE;
                end else begin
                    pend_len = off_add(pend_len, 1);
                end
            end
            M_INT, M_FRAC: begin
                if (digit_byte(b)) begin
                    pend_len = off_add(pend_len, 1);
                end else if (b == CH_DOT && scan_state == M_INT) begin
                    scan_state = M_DOT;
                end else begin
                    add_token(K_NUMBER, pend_start, pend_len, pend_line, pend_col);
                    scan_state = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_DOT: begin
                if (digit_byte(b)) begin
                    pend_len = off_add(pend_len, 2);
                    scan_state = M_FRAC;
                end else begin
                    add_number_and_dot();
                    scan_state = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_IDENT: begin
                if (word_byte(b)) begin
                    pend_len = off_add(pend_len, 1);
                end else begin
                    add_token(K_IDENT, pend_start, pend_len, pend_line, pend_col);
                    scan_state = M_IDLE;
                    rescan = 1'b1;
                end
            end
            default: begin
                scan_state = M_IDLE;
                rescan = 1'b1;
            end
        endcase

        // A byte not consumed above starts afresh.
        if (rescan) begin
            pk = punct_code(b);
            if (pk >= 0) begin
                add_token(kind_t'(pk), byte_pos, OFFSET_W'(1), cur_line, cur_col);
            end else if (b == CH_BANG || b == CH_GREAT || b == CH_LESS || b == CH_EQUAL) begin
                held_op = (b == CH_BANG) ? K_BANG : (b == CH_GREAT) ? K_GREATER :
                          (b == CH_LESS) ? K_LESS : K_EQUAL;
                open_pending(M_OP, byte_pos, OFFSET_W'(1));
            end else if (b == CH_SLASH) begin
                open_pending(M_SLASH, byte_pos, OFFSET_W'(1));
            end else if (b == CH_QUOTE) begin
                open_pending(M_STRING, off_add(byte_pos, 1), '0);
            end else if (b == CH_NL || b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
                // Whitespace only moves the counters.
            end else if (digit_byte(b)) begin
                open_pending(M_INT, byte_pos, OFFSET_W'(1));
            end else if (word_byte(b)) begin
                open_pending(M_IDENT, byte_pos, OFFSET_W'(1));
            end else begin
                add_token(K_ERROR, byte_pos, OFFSET_W'(1), cur_line, cur_col);
            end
        end

        // Position counters.
        byte_pos = off_add(byte_pos, 1);
        if (b == CH_NL) begin
            cur_line = line_add(cur_line, 1);
            cur_col  = '0;
        end else begin
            cur_col = line_add(cur_col, 1);
        end

        // End of text: flush the open token, add the end token, start over.
        if (fin) begin
            case (scan_state)
                M_OP:          add_token(held_op, pend_start, pend_len, pend_line, pend_col);
                M_SLASH:       add_token(K_SLASH, pend_start, pend_len, pend_line, pend_col);
                M_STRING:      add_token(K_STRING, pend_start, pend_len, pend_line, pend_col);
                M_INT, M_FRAC: add_token(K_NUMBER, pend_start, pend_len, pend_line, pend_col);
                M_DOT:         add_number_and_dot();
                M_IDENT:       add_token(K_IDENT, pend_start, pend_len, pend_line, pend_col);
                default:       ;
            endcase
            add_token(K_END, byte_pos, '0, cur_line, cur_col);
            scan_state = M_IDLE;
            held_op    = K_BANG;
            pend_start = '0;
            pend_len   = '0;
            pend_line  = '0;
            pend_col   = '0;
            byte_pos   = '0;
            cur_line   = '0;
            cur_col    = '0;
        end

        if (run_tokens.size() != 0)
            run_tokens[run_tokens.size() - 1].last_flag = 1'b1;
        foreach (run_tokens[i])
            token_queue.push_back(run_tokens[i]);
    endtask

    // Text building: bytes collect in text_bytes, the last one carries the end flag.
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endtask

    task automatic emit_text(input logic drain);
        src_byte_t sb;
        foreach (text_bytes[i]) begin
            sb.data        = text_bytes[i];
            sb.final_flag  = (i == text_bytes.size() - 1);
            sb.drain_first = drain && (i == 0);
            byte_queue.push_back(sb);
        end
        text_bytes.delete();
    endtask

    task automatic add_printable(input int count, input logic in_string);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (in_string && c == CH_QUOTE)
                c = "z";
            if (in_string && $urandom_range(0, 7) == 0)
                c = CH_NL;
            text_bytes.push_back(c);
        end
    endtask

    // One random lexeme, mostly well formed, sometimes noise.
    task automatic add_random_piece();
        string punct_set;
        int    n;
        punct_set = "(){}[],.-+;*?:\\";
        case ($urandom_range(0, 10))
            0, 1: text_bytes.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
            2: begin
                case ($urandom_range(0, 3))
                    0:       text_bytes.push_back(CH_BANG);
                    1:       text_bytes.push_back(CH_GREAT);
                    2:       text_bytes.push_back(CH_LESS);
                    default: text_bytes.push_back(CH_EQUAL);
                endcase
                if ($urandom_range(0, 1) == 1)
                    text_bytes.push_back(CH_EQUAL);
            end
            3: begin
                case ($urandom_range(0, 2))
                    0:       text_bytes.push_back(8'("a" + $urandom_range(0, 25)));
                    1:       text_bytes.push_back(8'("A" + $urandom_range(0, 25)));
                    default: text_bytes.push_back(CH_UNDER);
                endcase
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0:       text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                        1:       text_bytes.push_back(8'("A" + $urandom_range(0, 25)));
                        2:       text_bytes.push_back(CH_UNDER);
                        default: text_bytes.push_back(8'("a" + $urandom_range(0, 25)));
                    endcase
                end
            end
            4: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                case ($urandom_range(0, 5))
                    0, 1: begin
                        text_bytes.push_back(CH_DOT);
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++)
                            text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                    end
                    2: text_bytes.push_back(CH_DOT);
                    default: ;
                endcase
            end
            5: begin
                text_bytes.push_back(CH_QUOTE);
                add_printable($urandom_range(0, 5), 1'b1);
                text_bytes.push_back(CH_QUOTE);
            end
            6: begin
                add_str("//");
                add_printable($urandom_range(0, 6), 1'b0);
                text_bytes.push_back(CH_NL);
            end
            7: text_bytes.push_back(CH_SLASH);
            8: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0:       text_bytes.push_back(CH_TAB);
                        1:       text_bytes.push_back(CH_CR);
                        2:       text_bytes.push_back(CH_NL);
                        default: text_bytes.push_back(CH_SPACE);
                    endcase
                end
            end
            default: text_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Driver: offers bytes in bursts, predicting each byte's tokens as it goes
    // on the bus, since an offered beat is never withdrawn.
    int        burst_left = 0;
    int        gap_left   = 0;
    src_byte_t next_byte;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                bytes_accepted++;
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() == 0
                         || (byte_queue[0].drain_first && token_queue.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                next_byte = byte_queue.pop_front();
                scan_byte(next_byte.data, next_byte.final_flag);
                s_tdata  <= next_byte.data;
                s_tlast  <= next_byte.final_flag;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint exp, input longint act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            fail_count++;
        end
    endtask

    // Monitor: checks each accepted token beat and sets the ready pattern.
    int     hold_left    = 0;
    logic   hold_done    = 1'b0;
    int     stretch_left = 0;
    int     ready_style  = 0;
    token_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                tokens_seen++;
                if (token_queue.size() == 0) begin
                    $error("token beat with no token expected: kind %0d", m_tuser);
                    fail_count++;
                end else begin
                    want = token_queue.pop_front();
                    check_field("token_kind", want.kind, m_tuser);
                    check_field("start_offset", want.start, m_tdata[OFFSET_W-1:0]);
                    check_field("token_length", want.length,
                                m_tdata[2*OFFSET_W-1:OFFSET_W]);
                    check_field("line_number", want.line,
                                m_tdata[2*OFFSET_W+LINE_W-1:2*OFFSET_W]);
                    check_field("column_number", want.column,
                                m_tdata[2*OFFSET_W+2*LINE_W-1:2*OFFSET_W+LINE_W]);
                    check_field("last_of_run", want.last_flag, m_tlast);
                end
            end

            // One long hold-off lets the block fill up and stall its input.
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && tokens_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(8, 64);
                    ready_style  = $urandom_range(0, 3);
                end else begin
                    stretch_left--;
                end
                case (ready_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int waited;

        // Directed: fraction, two-char op, string with newline,
        // comment to newline, bytes at both ends of the range, a dot held at
        // the end of text, a lone slash, and an unterminated string.
        add_str("1.2.x<=\"q\n\"//c\n");
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        add_str("7.");
        emit_text(1'b0);
        add_str("/");
        emit_text(1'b0);
        add_str("\"ab");
        emit_text(1'b0);

        // Random texts; the first waits for the directed tokens to drain.
        bytes_total = byte_queue.size();
        while (byte_queue.size() < bytes_total + RANDOM_BYTES) begin
            repeat ($urandom_range(3, 14))
                add_random_piece();
            if ($urandom_range(0, 9) == 0) begin
                text_bytes.push_back(CH_QUOTE);
                add_printable($urandom_range(0, 3), 1'b1);
            end
            emit_text(byte_queue.size() == bytes_total);
        end
        bytes_total = byte_queue.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted < bytes_total)
            @(negedge aclk);
        waited = 0;
        while (token_queue.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        if (token_queue.size() != 0) begin
            $error("%0d expected tokens never arrived", token_queue.size());
            fail_count++;
        end
        repeat (20) @(negedge aclk);

        if (fail_count == 0) begin
            $display("source_text_tokenizer verification clean");
        end else begin
            $display("source_text_tokenizer verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("source_text_tokenizer verification failed");
        $finish;
    end

endmodule
